>>> hdl/booth_signed_multiplier_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Booth multiplier checker
// ----------------------------------------------------------------------------
`ifndef BOOTH_SIGNED_MULTIPLIER_TOP_MACROS_SVH
`define BOOTH_SIGNED_MULTIPLIER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define BSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds after ante, delayed by dly
`define BSM_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

>>> hdl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the radix-2 Booth multiplier.
// ----------------------------------------------------------------------------
package bsm_pkg;

  // Default operand width
  localparam int unsigned WidthDef = 8;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture operands, clear accumulator
    logic step;   // one add/subtract and shift round
  } cmd_t;

endpackage

>>> hdl/bsm_datapath.sv
// ----------------------------------------------------------------------------
// bsm_datapath
// Accumulator, multiplier and previous-bit registers with the shared
// add/subtract unit; one Booth round per step command.
// ----------------------------------------------------------------------------
module bsm_datapath #(
  parameter int unsigned WIDTH = bsm_pkg::WidthDef
) (
  input  logic                        clk_i,
  input  bsm_pkg::cmd_t               cmd_i,
  input  logic signed [WIDTH-1:0]     multiplicand_i,
  input  logic signed [WIDTH-1:0]     multiplier_i,
  output logic signed [2*WIDTH-1:0]   product_o
);

  logic [WIDTH:0]   acc_q, acc_d;
  logic [WIDTH:0]   m_q, m_d;
  logic [WIDTH-1:0] q_q, q_d;
  logic             prev_q, prev_d;
  logic [WIDTH:0]   sum;

  // Pick subtract, add or hold from the current and previous multiplier bit
  always_comb begin
    unique case ({q_q[0], prev_q})
      2'b10:   sum = acc_q - m_q;
      2'b01:   sum = acc_q + m_q;
      default: sum = acc_q;
    endcase
  end

  // Load operands or advance one round with an arithmetic right shift
  always_comb begin
    acc_d  = acc_q;
    m_d    = m_q;
    q_d    = q_q;
    prev_d = prev_q;
    if (cmd_i.load) begin
      acc_d  = '0;
      m_d    = {multiplicand_i[WIDTH-1], multiplicand_i};
      q_d    = multiplier_i;
      prev_d = 1'b0;
    end else if (cmd_i.step) begin
      acc_d  = {sum[WIDTH], sum[WIDTH:1]};
      q_d    = {sum[0], q_q[WIDTH-1:1]};
      prev_d = q_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    m_q    <= m_d;
    q_q    <= q_d;
    prev_q <= prev_d;
  end

  // Product is the low accumulator bits over the shifted multiplier
  assign product_o = {acc_q[WIDTH-1:0], q_q};

endmodule

>>> hdl/bsm_controller.sv
// ----------------------------------------------------------------------------
// bsm_controller
// Sequencer of the Booth multiplier: takes a transfer, counts the rounds
// and raises the result strobe.
// ----------------------------------------------------------------------------
module bsm_controller #(
  parameter int unsigned WIDTH = bsm_pkg::WidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output bsm_pkg::cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] LastRound = CntW'(WIDTH - 1);

  bsm_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign accept = start && !busy;

  // Next state and round count
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      bsm_pkg::StIdle: begin
        if (accept) begin
          state_d = bsm_pkg::StRun;
          cnt_d   = '0;
        end
      end
      bsm_pkg::StRun: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastRound) begin
          state_d = bsm_pkg::StDone;
        end
      end
      bsm_pkg::StDone: begin
        cnt_d = '0;
        if (accept) begin
          state_d = bsm_pkg::StRun;
        end else begin
          state_d = bsm_pkg::StIdle;
        end
      end
      default: begin
        state_d = bsm_pkg::StIdle;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsm_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Drive status and datapath commands
  assign busy       = (state_q == bsm_pkg::StRun);
  assign done_o     = (state_q == bsm_pkg::StDone);
  assign cmd_o.load = accept;
  assign cmd_o.step = busy;

endmodule

>>> hdl/booth_signed_multiplier_top.sv
// ----------------------------------------------------------------------------
// booth_signed_multiplier_top
// Radix-2 Booth multiplier for two's-complement operands of WIDTH bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive multiplicand_i and multiplier_i and raise start; the
//   transfer takes place at the clock edge where start is high and busy is
//   low. Operands are captured at that edge.
//   Work: busy stays high while the rounds run, one add/subtract-and-shift
//   round per cycle through the single accumulator adder.
//   Output: product_o carries the signed 2*WIDTH-bit product, marked by done_o
//   for exactly one cycle right after the last round. The receiver cannot
//   stall; the result is taken at the edge that ends that cycle.
//   Throughput: a new transfer can be taken in the done_o cycle but not while
//   busy is high; done_o rises after the last round and the product is taken
//   at the edge that ends the done_o cycle.
//   Reset: rst_ni clears the sequencer to idle with busy and done_o low;
//   the operand registers are not reset.
// ----------------------------------------------------------------------------
module booth_signed_multiplier_top #(
  parameter int unsigned WIDTH = bsm_pkg::WidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [WIDTH-1:0]   multiplicand_i,
  input  logic signed [WIDTH-1:0]   multiplier_i,
  output logic                      done_o,
  output logic signed [2*WIDTH-1:0] product_o
);

  bsm_pkg::cmd_t cmd;

  // Sequencer
  bsm_controller #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .cmd_o (cmd)
  );

  // Accumulator and shift registers
  bsm_datapath #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .multiplicand_i(multiplicand_i),
    .multiplier_i  (multiplier_i),
    .product_o     (product_o)
  );

endmodule

>>> hdl/bsm_checker.sv
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level timing checks of the Booth multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`include "booth_signed_multiplier_top_macros.svh"

module bsm_checker #(
  parameter int unsigned WIDTH = bsm_pkg::WidthDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // Result strobe never overlaps the rounds
  `BSM_ASSERT_IMPL(a_done_not_busy, done_o, !busy, "done_o while busy")
  // End of the rounds always shows a result
  `BSM_ASSERT_IMPL(a_fall_done, $fell(busy), done_o, "busy fell without done_o")
  // An accepted transfer starts the rounds
  `BSM_ASSERT_DELAY(a_accept_busy, start && !busy, 1, busy, "no rounds after transfer")
  // Result appears a fixed number of cycles after the transfer
  `BSM_ASSERT_DELAY(a_latency, start && !busy, WIDTH + 1, done_o, "result latency wrong")

endmodule

bind booth_signed_multiplier_top bsm_checker #(
  .WIDTH(WIDTH)
) u_bsm_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o)
);
